// File: sv/bat_pkg.sv
// Shared types and constants for the block address translation unit.
// Used by bat_cell, block_address_translation and bat_checker; no dependencies.
package bat_pkg;

    localparam int unsigned ENTRIES_PER_SIDE_DEF = 8;
    localparam int unsigned PAIR_W               = 3;

    typedef enum logic {
        CMD_WRITE     = 1'b0,
        CMD_TRANSLATE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_WRITTEN = 3'd0,
        ST_PASS    = 3'd1,
        ST_HIT     = 3'd2,
        ST_MISS    = 3'd3,
        ST_PROT    = 3'd4,
        ST_GUARD   = 3'd5
    } t_status;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;

    localparam logic [1:0] PROT_NONE = 2'd0;
    localparam logic [1:0] PROT_RW   = 2'd2;

    localparam logic [10:0] VEC_NONE = 11'h000;
    localparam logic [10:0] VEC_DSI  = 11'h300;
    localparam logic [10:0] VEC_ISI  = 11'h400;

    localparam logic [31:0] BL_FIELD_MASK = 32'h0000_1FFC;
    localparam logic [16:0] BLOCK_LOW_MASK = 17'h1_FFFF;
    localparam logic [31:0] BEPI_MASK     = 32'hFFFE_0000;
    localparam logic [31:0] SYN_PROT      = 32'h0800_0000;
    localparam logic [31:0] SYN_STORE     = 32'h0200_0000;
    localparam logic [31:0] SYN_GUARD     = 32'h1000_0000;

    typedef struct packed {
        t_cmd        command;
        logic [4:0]  bat_index;
        logic [31:0] bat_value;
        logic [31:0] virtual_address;
        logic [1:0]  access_kind;
        logic        user_mode;
        logic        fetch_translate_on;
        logic        data_translate_on;
    } t_bat_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] physical_address;
        logic [10:0] exception_vector;
        logic [31:0] fault_syndrome;
        logic [31:0] fault_address;
    } t_bat_out;

    // One item in flight along the cell chain, with its result so far.
    typedef struct packed {
        t_bat_in  item;
        logic     done;
        t_bat_out res;
    } t_token;

endpackage

// File: sv/bat_cell.sv
// One cell of the translation chain: holds BAT pair CELL_INDEX of both sides.
// Depends on bat_pkg.
module bat_cell import bat_pkg::*; #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  logic   i_valid,
    input  t_token i_tok,
    output logic   o_valid,
    output t_token o_tok
);

    logic [31:0] r_iupper, r_ilower, r_dupper, r_dlower;
    logic        r_valid;
    t_token      r_tok;
    t_token      n_tok;

    logic        fetch;
    logic        store;
    logic        xlat_on;
    logic [31:0] upper, lower, mask;
    logic        pair_valid, tag_match;
    logic [1:0]  prot;
    logic        my_pair;

    // Access kind 3 has the fetch bit set and is handled as a fetch.
    assign fetch   = i_tok.item.access_kind[1];
    assign store   = (i_tok.item.access_kind == KIND_WRITE);
    assign xlat_on = fetch ? i_tok.item.fetch_translate_on : i_tok.item.data_translate_on;
    assign upper   = fetch ? r_iupper : r_dupper;
    assign lower   = fetch ? r_ilower : r_dlower;
    assign mask    = {4'b0000, upper[12:2], BLOCK_LOW_MASK};
    assign pair_valid = i_tok.item.user_mode ? upper[0] : upper[1];
    assign tag_match  = ((i_tok.item.virtual_address & ~mask) == (upper & BEPI_MASK & ~mask));
    assign prot       = lower[1:0];
    assign my_pair    = (i_tok.item.bat_index[3:1] == PAIR_W'(CELL_INDEX));

    always_comb begin
        n_tok = i_tok;
        if (i_tok.item.command == CMD_WRITE) begin
            n_tok.done = 1'b1;
            n_tok.res  = '0;
            n_tok.res.status = ST_WRITTEN;
        end else if (!i_tok.done) begin
            if (!xlat_on) begin
                n_tok.done = 1'b1;
                n_tok.res  = '0;
                n_tok.res.status = ST_PASS;
                n_tok.res.physical_address = i_tok.item.virtual_address;
            end else if (pair_valid && tag_match) begin
                n_tok.done = 1'b1;
                n_tok.res  = '0;
                if (prot == PROT_NONE || (store && prot != PROT_RW)) begin
                    n_tok.res.status = ST_PROT;
                    n_tok.res.fault_syndrome = SYN_PROT;
                    if (fetch) begin
                        n_tok.res.exception_vector = VEC_ISI;
                    end else begin
                        n_tok.res.exception_vector = VEC_DSI;
                        n_tok.res.fault_address = i_tok.item.virtual_address;
                        if (store) begin
                            n_tok.res.fault_syndrome = SYN_PROT | SYN_STORE;
                        end
                    end
                end else if (fetch && lower[3]) begin
                    n_tok.res.status = ST_GUARD;
                    n_tok.res.exception_vector = VEC_ISI;
                    n_tok.res.fault_syndrome = SYN_GUARD;
                end else begin
                    n_tok.res.status = ST_HIT;
                    n_tok.res.physical_address = (lower & BEPI_MASK & ~mask)
                                               | (i_tok.item.virtual_address & mask);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iupper <= '0;
            r_ilower <= '0;
            r_dupper <= '0;
            r_dlower <= '0;
        end else if (i_advance && i_valid && i_tok.item.command == CMD_WRITE && my_pair) begin
            unique case ({i_tok.item.bat_index[4], i_tok.item.bat_index[0]})
                2'b00: r_iupper <= i_tok.item.bat_value;
                2'b01: r_ilower <= i_tok.item.bat_value;
                2'b10: r_dupper <= i_tok.item.bat_value;
                2'b11: r_dlower <= i_tok.item.bat_value;
                default: r_dlower <= i_tok.item.bat_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// File: sv/block_address_translation.sv
// Top level of the block address translation unit: a chain of bat_cell stages.
// Depends on bat_pkg and bat_cell.
//
// Each transfer is a BAT word write or an address translation, and each gives one result.
// The unit is a chain of ENTRIES_PER_SIDE cells; cell p holds BAT pair p of the instruction
// and data sides, and every item walks the whole chain, moving one cell each time the
// chain advances, so its result leaves from the last cell. Writes travel the same chain,
// so the order of writes and lookups is kept, and a new item is taken every cycle while
// the output side is not stalled. The last cell's register is the output register. Words
// of pairs at or beyond ENTRIES_PER_SIDE are accepted but not stored. All BAT words read
// as zero after reset.
module block_address_translation import bat_pkg::*; #(
    parameter int unsigned ENTRIES_PER_SIDE = ENTRIES_PER_SIDE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_bat_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_bat_out o_data
);

    logic   [ENTRIES_PER_SIDE:0] chain_valid;
    t_token                      chain_tok [0:ENTRIES_PER_SIDE];
    logic                        advance;

    // The whole chain moves when the output register is empty or being taken.
    assign advance = !chain_valid[ENTRIES_PER_SIDE] || !i_stall;
    assign o_stall = !advance;

    always_comb begin
        chain_tok[0]      = '0;
        chain_tok[0].item = i_data;
        chain_tok[0].done = 1'b0;
        chain_tok[0].res.status = ST_MISS;
    end
    assign chain_valid[0] = i_valid;

    for (genvar g = 0; g < ENTRIES_PER_SIDE; g++) begin : g_cell
        bat_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_valid   (chain_valid[g]),
            .i_tok     (chain_tok[g]),
            .o_valid   (chain_valid[g+1]),
            .o_tok     (chain_tok[g+1])
        );
    end

    assign o_valid = chain_valid[ENTRIES_PER_SIDE];
    assign o_data  = chain_tok[ENTRIES_PER_SIDE].res;

endmodule

// File: sv/bat_checker.sv
// Port-level checks for block_address_translation, attached by the bind below.
// Depends on bat_pkg.
module bat_checker import bat_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input t_bat_in  i_data,
    input logic     o_valid,
    input logic     i_stall,
    input t_bat_out o_data
);

    // A stalled input stays in place until its transfer.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input changed while stalled");

    // A stalled result stays in place until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_MISS |->
            o_data.physical_address == '0 && o_data.exception_vector == VEC_NONE &&
            o_data.fault_syndrome == '0 && o_data.fault_address == '0)
        else $error("miss result carries data");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_HIT || o_data.status == ST_PASS) |->
            o_data.exception_vector == VEC_NONE && o_data.fault_syndrome == '0)
        else $error("translated result carries a fault");

    a_fault_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_PROT || o_data.status == ST_GUARD) |->
            o_data.physical_address == '0 &&
            (o_data.exception_vector == VEC_DSI || o_data.exception_vector == VEC_ISI))
        else $error("fault result without storage vector");

endmodule

bind block_address_translation bat_checker u_bat_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for block_address_translation: BAT word writes and lookups.
// Depends on bat_pkg and the block's RTL; results are checked against a predictor
// that keeps its own copy of the 32 BAT words, or against typed-in expectations.
module tb_top;
    import bat_pkg::*;

    localparam int unsigned LATENCY      = ENTRIES_PER_SIDE_DEF;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned GUARD_BIT    = 3;
    localparam int unsigned VS_BIT       = 1;
    localparam int unsigned VP_BIT       = 0;
    localparam logic [1:0]  KIND_FETCH   = 2'd2;
    localparam logic [1:0]  KIND_UNDEF   = 2'd3;
    localparam t_bat_out    NO_RESULT    = '0;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct {
        t_bat_in  item;
        bit       typed;
        t_bat_out result;
    } t_directed_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_bat_in  i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_bat_out o_data;

    // Travels with i_data: a typed-in expectation for directed rows.
    bit       row_typed  = 1'b0;
    t_bat_out row_result = '0;

    logic [31:0]   bat_table [32];
    t_bat_out      pending_results [$];
    t_directed_row directed_rows [$];
    bit            failed = 1'b0;

    block_address_translation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_bat_out bat_translate(input t_bat_in it);
        t_bat_out    r;
        logic        fetch;
        logic        store;
        logic [31:0] upper;
        logic [31:0] lower;
        logic [31:0] blk_mask;
        logic [1:0]  prot;
        int          base;
        r = '0;
        if (it.command == CMD_WRITE) begin
            bat_table[it.bat_index] = it.bat_value;
            return r;
        end
        // Access kind 3 has bit 1 set and so goes down the instruction side.
        fetch = it.access_kind[1];
        store = (it.access_kind == KIND_WRITE);
        if (!(fetch ? it.fetch_translate_on : it.data_translate_on)) begin
            r.status = ST_PASS;
            r.physical_address = it.virtual_address;
            return r;
        end
        base = fetch ? 0 : 16;
        for (int p = 0; p < ENTRIES_PER_SIDE_DEF; p++) begin
            upper = bat_table[base + 2 * p];
            lower = bat_table[base + 2 * p + 1];
            if (!upper[it.user_mode ? VP_BIT : VS_BIT]) continue;
            blk_mask = ((upper & BL_FIELD_MASK) << 15) | 32'(BLOCK_LOW_MASK);
            if ((it.virtual_address & ~blk_mask) != (upper & BEPI_MASK & ~blk_mask)) continue;
            prot = lower[1:0];
            if (prot == PROT_NONE || (store && prot != PROT_RW)) begin
                r.status = ST_PROT;
                r.fault_syndrome = SYN_PROT;
                if (fetch) begin
                    r.exception_vector = VEC_ISI;
                end else begin
                    r.exception_vector = VEC_DSI;
                    r.fault_address = it.virtual_address;
                    if (store) r.fault_syndrome = SYN_PROT | SYN_STORE;
                end
            end else if (fetch && lower[GUARD_BIT]) begin
                r.status = ST_GUARD;
                r.exception_vector = VEC_ISI;
                r.fault_syndrome = SYN_GUARD;
            end else begin
                r.status = ST_HIT;
                r.physical_address = (lower & BEPI_MASK & ~blk_mask)
                                   | (it.virtual_address & blk_mask);
            end
            return r;
        end
        r.status = ST_MISS;
        return r;
    endfunction

    function automatic t_bat_in write_cmd(input logic [4:0] idx, input logic [31:0] val);
        t_bat_in it;
        it = '0;
        it.command = CMD_WRITE;
        it.bat_index = idx;
        it.bat_value = val;
        // Lookup fields carry junk that a write has to ignore.
        it.virtual_address = ~val;
        it.access_kind = KIND_FETCH;
        it.data_translate_on = 1'b1;
        return it;
    endfunction

    function automatic t_bat_in lookup_cmd(input logic [31:0] addr, input logic [1:0] kind,
                                           input logic user, input logic ir, input logic dr);
        t_bat_in it;
        it = '0;
        it.command = CMD_TRANSLATE;
        it.bat_index = 5'h1F;
        it.virtual_address = addr;
        it.access_kind = kind;
        it.user_mode = user;
        it.fetch_translate_on = ir;
        it.data_translate_on = dr;
        return it;
    endfunction

    function automatic t_bat_out result_of(input t_status st, input logic [31:0] pa,
                                           input logic [10:0] vec, input logic [31:0] syn,
                                           input logic [31:0] fa);
        t_bat_out r;
        r.status = st;
        r.physical_address = pa;
        r.exception_vector = vec;
        r.fault_syndrome = syn;
        r.fault_address = fa;
        return r;
    endfunction

    task automatic add_row(input t_bat_in it, input bit typed, input t_bat_out res);
        t_directed_row row;
        row.item = it;
        row.typed = typed;
        row.result = res;
        directed_rows.push_back(row);
    endtask

    function automatic t_bat_in random_item();
        t_bat_in     it;
        logic [31:0] upper;
        logic [31:0] blk_mask;
        int          roll;
        int          base;
        int          k;
        it.command = CMD_TRANSLATE;
        it.bat_index = 5'($urandom_range(0, 31));
        it.bat_value = $urandom();
        it.virtual_address = $urandom();
        it.access_kind = ($urandom_range(0, 7) == 0) ? KIND_UNDEF : 2'($urandom_range(0, 2));
        it.user_mode = 1'($urandom_range(0, 1));
        it.fetch_translate_on = 1'($urandom_range(0, 1));
        it.data_translate_on = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            it.command = CMD_WRITE;
            // Half the upper words get a legal block length: a run of ones from bit 2.
            if (!it.bat_index[0] && $urandom_range(0, 1) == 1) begin
                k = $urandom_range(0, 11);
                it.bat_value[12:2] = 11'((1 << k) - 1);
            end
        end else if (roll < 90) begin
            // Aim at the tag of one pair of the side so that lookups get past the compare.
            if ($urandom_range(0, 9) != 0) begin
                it.fetch_translate_on = 1'b1;
                it.data_translate_on = 1'b1;
            end
            base = it.access_kind[1] ? 0 : 16;
            upper = bat_table[base + 2 * $urandom_range(0, ENTRIES_PER_SIDE_DEF - 1)];
            blk_mask = ((upper & BL_FIELD_MASK) << 15) | 32'(BLOCK_LOW_MASK);
            it.virtual_address = (upper & BEPI_MASK & ~blk_mask)
                               | (it.virtual_address & blk_mask);
        end
        return it;
    endfunction

    task automatic check_result(input t_bat_out want, input t_bat_out got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failed = 1'b1;
        end
        if (got.physical_address !== want.physical_address) begin
            $error("physical_address: expected %h, actual %h",
                   want.physical_address, got.physical_address);
            failed = 1'b1;
        end
        if (got.exception_vector !== want.exception_vector) begin
            $error("exception_vector: expected %h, actual %h",
                   want.exception_vector, got.exception_vector);
            failed = 1'b1;
        end
        if (got.fault_syndrome !== want.fault_syndrome) begin
            $error("fault_syndrome: expected %h, actual %h",
                   want.fault_syndrome, got.fault_syndrome);
            failed = 1'b1;
        end
        if (got.fault_address !== want.fault_address) begin
            $error("fault_address: expected %h, actual %h",
                   want.fault_address, got.fault_address);
            failed = 1'b1;
        end
    endtask

    // Results are retired before the same edge's input transfer is predicted.
    always @(posedge i_clk) begin : result_check
        t_bat_out predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("status: expected no result, actual %0d", o_data.status);
                    failed = 1'b1;
                end else begin
                    check_result(pending_results.pop_front(), o_data);
                end
            end
            if (i_valid && !o_stall) begin
                predicted = bat_translate(i_data);
                pending_results.push_back(row_typed ? row_result : predicted);
            end
        end
    end

    initial begin : output_stall
        t_stall_mode mode;
        int          span;
        int unsigned tick;
        tick = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(32, 200);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                case (mode)
                    STALL_NONE: begin
                        i_stall <= 1'b0;
                    end
                    STALL_COIN: begin
                        i_stall <= 1'($urandom_range(0, 1));
                    end
                    STALL_PERIODIC: begin
                        i_stall <= (tick % 3 == 0);
                    end
                    default: begin
                        i_stall <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        t_bat_in item;
        bit      typed;
        t_bat_out res;
        int      burst_left;
        int      total;
        t_bat_in fetch_guard;

        bat_table = '{default: '0};

        // Reset state: data translation on with an empty table misses.
        add_row(lookup_cmd(32'h1234_5678, KIND_READ, 1'b0, 1'b1, 1'b1), 1'b1,
                result_of(ST_MISS, '0, VEC_NONE, '0, '0));
        add_row(lookup_cmd(32'hFFFF_FFFF, KIND_FETCH, 1'b1, 1'b0, 1'b1), 1'b1,
                result_of(ST_PASS, 32'hFFFF_FFFF, VEC_NONE, '0, '0));
        add_row(lookup_cmd(32'h0000_0000, KIND_WRITE, 1'b0, 1'b1, 1'b0), 1'b1,
                result_of(ST_PASS, '0, VEC_NONE, '0, '0));
        // Data pair 0: 128 KB block at 0x8000_0000, both valid bits, read/write.
        add_row(write_cmd(5'd16, 32'h8000_0003), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd17, 32'h1234_0002), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h8001_ABCD, KIND_READ, 1'b0, 1'b0, 1'b1), 1'b0, NO_RESULT);
        add_row(lookup_cmd(32'h8001_FFFF, KIND_WRITE, 1'b1, 1'b0, 1'b1), 1'b0, NO_RESULT);
        // Data pair 1: largest block at zero, supervisor only, read-only.
        add_row(write_cmd(5'd18, 32'h0000_1FFE), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd19, 32'hFFFE_0001), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h0FFF_FFFF, KIND_WRITE, 1'b0, 1'b0, 1'b1), 1'b1,
                result_of(ST_PROT, '0, VEC_DSI, SYN_PROT | SYN_STORE, 32'h0FFF_FFFF));
        add_row(lookup_cmd(32'h0FFF_FFFF, KIND_READ, 1'b0, 1'b0, 1'b1), 1'b0, NO_RESULT);
        add_row(lookup_cmd(32'h0000_0000, KIND_READ, 1'b1, 1'b0, 1'b1), 1'b0, NO_RESULT);
        // Instruction pair 0 has no access at all.
        add_row(write_cmd(5'd0, 32'h4000_0002), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd1, 32'h0000_0000), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h4000_0010, KIND_FETCH, 1'b0, 1'b1, 1'b0), 1'b1,
                result_of(ST_PROT, '0, VEC_ISI, SYN_PROT, '0));
        // Instruction pair 1 is guarded, so a fetch through it faults.
        add_row(write_cmd(5'd2, 32'hFFFE_1FFF), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd3, 32'h0000_000A), 1'b1, NO_RESULT);
        fetch_guard = lookup_cmd(32'hF000_1234, KIND_FETCH, 1'b1, 1'b1, 1'b0);
        add_row(fetch_guard, 1'b1, result_of(ST_GUARD, '0, VEC_ISI, SYN_GUARD, '0));
        fetch_guard.access_kind = KIND_UNDEF;
        add_row(fetch_guard, 1'b1, result_of(ST_GUARD, '0, VEC_ISI, SYN_GUARD, '0));
        // Data read through a no-access pair.
        add_row(write_cmd(5'd20, 32'h2000_0001), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd21, 32'h0000_0000), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h2000_0000, KIND_READ, 1'b1, 1'b0, 1'b1), 1'b1,
                result_of(ST_PROT, '0, VEC_DSI, SYN_PROT, 32'h2000_0000));
        // Pair 7 is shadowed by pair 0: the lower pair wins until it is invalidated.
        add_row(write_cmd(5'd30, 32'h8000_0003), 1'b1, NO_RESULT);
        add_row(write_cmd(5'd31, 32'hFFFF_FFFF), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h8000_0000, KIND_READ, 1'b0, 1'b0, 1'b1), 1'b0, NO_RESULT);
        add_row(write_cmd(5'd16, 32'h8000_0000), 1'b1, NO_RESULT);
        add_row(lookup_cmd(32'h8000_0000, KIND_READ, 1'b0, 1'b0, 1'b1), 1'b0, NO_RESULT);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        total = directed_rows.size() + RANDOM_ITEMS;
        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < total; n++) begin
            if (n < directed_rows.size()) begin
                item = directed_rows[n].item;
                typed = directed_rows[n].typed;
                res = directed_rows[n].result;
            end else begin
                item = random_item();
                typed = 1'b0;
                res = NO_RESULT;
            end
            i_data <= item;
            row_typed <= typed;
            row_result <= res;
            i_valid <= 1'b1;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
